// ===== hw/rtl/rsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsr_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 4096;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
   localparam int SUM_W      = COUNT_W + 1;

   // Register and field widths
   localparam int CAP_W      = 13;
   localparam int EPOCH_W    = 32;
   localparam int INDEX_W    = 64;
   localparam int IQ_W       = 16;
   localparam int WORD_W     = 2 * IQ_W;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CMP_W      = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;

   localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(4096);
   localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(1);
   localparam logic [INDEX_W-1:0] START_RESET = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY = 2'd0,
      CSR_EPOCH    = 2'd1,
      CSR_START    = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_APPEND = 1'b0,
      ACT_READ   = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_STALE       = 3'd1,
      ST_LOSS        = 3'd2,
      ST_OVERWRITTEN = 3'd3,
      ST_NOT_READY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_ACCESS,
      S_FETCH,
      S_EMIT
   } fsm_type;

   typedef struct packed {
      action_type               action;
      logic [EPOCH_W-1:0]       epoch_tag;
      logic [INDEX_W-1:0]       sample_index;
      logic signed [IQ_W-1:0]   i_value;
      logic signed [IQ_W-1:0]   q_value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [IQ_W-1:0]   i_sample;
      logic signed [IQ_W-1:0]   q_sample;
   } rsp_type;

   // Outcome of the check stage, consumed by the access stage
   typedef struct packed {
      status_type               status;
      logic                     do_append;
      logic                     do_read;
      logic                     go_loss;
      logic [SLOT_W-1:0]        base;
      logic [COUNT_W-1:0]       span;
   } chk_type;

   // What the window hands back to the sequencer
   typedef struct packed {
      status_type               status;
      logic                     fetch;
   } verdict_type;

   typedef struct packed {
      logic                     we;
      logic                     re;
      logic [SLOT_W-1:0]        addr;
      logic [WORD_W-1:0]        wdata;
   } mem_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rsr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                      clock,
   input  wire logic                      we,
   input  wire logic                      re,
   input  wire logic [$clog2(DEPTH)-1:0]  addr,
   input  wire logic [WIDTH-1:0]          wdata,
   output logic      [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rsr_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsr_window import rsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata,
   input  wire req_type               req,
   input  wire logic                  check_en,
   input  wire logic                  access_en,
   output verdict_type                verdict,
   output mem_cmd_type                mem_cmd
);

   // config registers
   logic [CAP_W-1:0]   cap_ff,   cap_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [INDEX_W-1:0] start_ff, start_in;
   logic               reinit;

   // window state
   logic [SLOT_W-1:0]  oldest_ff, oldest_in;
   logic [COUNT_W-1:0] held_ff,   held_in;
   logic [INDEX_W-1:0] next_ff,   next_in;
   logic               source_ok_ff, source_ok_in;

   chk_type            chk_ff, chk_in;

   logic [COUNT_W-1:0] cap;
   logic [CMP_W-1:0]   cap_ext;
   logic [INDEX_W-1:0] first;
   logic               below, beyond, gap, full;
   logic [COUNT_W-1:0] oldest_inc;
   logic [SLOT_W-1:0]  oldest_wrap;
   logic [SUM_W-1:0]   pos_sum, pos;

   // effective capacity: zero acts as one, clamp to depth
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap = COUNT_W'(1);
      end else if (cap_ext > CMP_W'(RING_DEPTH)) begin
         cap = COUNT_W'(RING_DEPTH);
      end else begin
         cap = COUNT_W'(cap_ext);
      end
   end

   always_comb begin
      cap_in   = cap_ff;
      epoch_in = epoch_ff;
      start_in = start_ff;
      reinit   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: begin
               cap_in = csr_wdata[CAP_W-1:0];
               reinit = 1'b1;
            end
            CSR_EPOCH: begin
               epoch_in = csr_wdata[EPOCH_W-1:0];
               reinit   = 1'b1;
            end
            CSR_START: begin
               start_in = csr_wdata[INDEX_W-1:0];
               reinit   = 1'b1;
            end
            default: begin
               reinit = 1'b0;
            end
         endcase
      end
   end

   // check stage
   always_comb begin
      first       = next_ff - INDEX_W'(held_ff);
      below       = req.sample_index < first;
      beyond      = req.sample_index >= next_ff;
      gap         = (req.sample_index != next_ff) || (&next_ff);
      full        = held_ff >= cap;
      oldest_inc  = COUNT_W'(oldest_ff) + COUNT_W'(1);
      oldest_wrap = (oldest_inc == cap) ? '0 : oldest_inc[SLOT_W-1:0];

      chk_in           = chk_ff;
      chk_in.do_append = 1'b0;
      chk_in.do_read   = 1'b0;
      chk_in.go_loss   = 1'b0;
      chk_in.status    = ST_OK;
      if (req.epoch_tag != epoch_ff) begin
         chk_in.status = ST_STALE;
      end else if (!source_ok_ff) begin
         chk_in.status = ST_LOSS;
      end else if (req.action == ACT_APPEND) begin
         if (gap) begin
            chk_in.status  = ST_LOSS;
            chk_in.go_loss = 1'b1;
         end else begin
            chk_in.do_append = 1'b1;
            chk_in.base      = full ? oldest_wrap : oldest_ff;
            chk_in.span      = full ? (cap - COUNT_W'(1)) : held_ff;
         end
      end else begin
         if (below) begin
            chk_in.status = ST_OVERWRITTEN;
         end else if (beyond) begin
            chk_in.status = ST_NOT_READY;
         end else begin
            chk_in.do_read = 1'b1;
            chk_in.base    = oldest_ff;
            chk_in.span    = req.sample_index[COUNT_W-1:0] - first[COUNT_W-1:0];
         end
      end
   end

   // access stage: slot = (base + span) mod cap, sum stays below 2*cap
   always_comb begin
      pos_sum = SUM_W'(chk_ff.base) + SUM_W'(chk_ff.span);
      pos     = (pos_sum >= SUM_W'(cap)) ? (pos_sum - SUM_W'(cap)) : pos_sum;

      mem_cmd.we    = access_en && chk_ff.do_append;
      mem_cmd.re    = access_en && chk_ff.do_read;
      mem_cmd.addr  = pos[SLOT_W-1:0];
      mem_cmd.wdata = {req.q_value, req.i_value};

      verdict.status = chk_ff.status;
      verdict.fetch  = chk_ff.do_read;
   end

   always_comb begin
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      next_in      = next_ff;
      source_ok_in = source_ok_ff;
      if (reinit) begin
         oldest_in    = '0;
         held_in      = '0;
         next_in      = start_in;
         source_ok_in = (epoch_in != '0);
      end else if (access_en && chk_ff.go_loss) begin
         held_in      = '0;
         source_ok_in = 1'b0;
      end else if (access_en && chk_ff.do_append) begin
         oldest_in = chk_ff.base;
         held_in   = chk_ff.span + COUNT_W'(1);
         next_in   = next_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         epoch_ff     <= EPOCH_RESET;
         start_ff     <= START_RESET;
         oldest_ff    <= '0;
         held_ff      <= '0;
         next_ff      <= START_RESET;
         source_ok_ff <= 1'b1;
         chk_ff       <= '0;
      end else begin
         cap_ff       <= cap_in;
         epoch_ff     <= epoch_in;
         start_ff     <= start_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         next_ff      <= next_in;
         source_ok_ff <= source_ok_in;
         if (check_en) begin
            chk_ff <= chk_in;
         end
      end
   end

   // ring never holds more than its capacity
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap)
      else $error("held count above capacity");

   // oldest slot stays inside the ring
   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'(oldest_ff) < cap)
      else $error("oldest slot outside ring");

endmodule

`default_nettype wire

// ===== hw/rtl/recent_iq_sample_ring_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Recent IQ sample ring. Keeps the last ring_capacity IQ samples of a stream
// in a RING_DEPTH x 32 single-port RAM, each sample addressed by its 64-bit
// absolute index, under a session epoch. An append beat must carry exactly
// the next expected index; a gap (or an append at the maximum index) puts
// the ring into source loss until any register is written. A full ring
// evicts its oldest sample. Every beat, append or read, returns one result
// beat with a status (ok, stale epoch, source loss, overwritten, not ready)
// and, for an ok read, the stored I and Q values (zero otherwise).
// Flow: one beat is in flight at a time. Between one acceptance and the
// next, an append or a failed read passes through capture, check, RAM
// access and result hand-off; an ok read also passes through a fetch step,
// the registered read of the sample RAM. The result sits in an output
// register, so a new beat is taken while an earlier result waits; the
// hand-off step stalls only if that register is still occupied.
// No clearing pass after reset: RAM contents are never read before written.
// Registers are to be written through csr_we/csr_index/csr_wdata only while
// idle, not enforced by the block; a register write restarts the window at start_index.

module recent_iq_sample_ring_core import rsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   fsm_type       state_ff, state_in;
   req_type       req_ff;
   rsp_type       res_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          check_en, access_en, fetch_en, emit_en;
   verdict_type   verdict;
   mem_cmd_type   mem_cmd;
   logic [WORD_W-1:0] rd_data;

   // Window state, position math and config registers
   rsr_window u_window (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ff),
      .check_en  (check_en),
      .access_en (access_en),
      .verdict   (verdict),
      .mem_cmd   (mem_cmd)
   );

   // Sample store: i in the low half, q in the high half
   rsr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_cmd.we),
      .re    (mem_cmd.re),
      .addr  (mem_cmd.addr),
      .wdata (mem_cmd.wdata),
      .rdata (rd_data)
   );

   // Output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer. Only one beat in flight, so the RAM write of an append and a
   // later read of the same slot never overlap: no forwarding needed.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      check_en  = 1'b0;
      access_en = 1'b0;
      fetch_en  = 1'b0;
      emit_en   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            check_en = 1'b1;
            state_in = S_ACCESS;
         end
         S_ACCESS: begin
            access_en = 1'b1;
            state_in  = verdict.fetch ? S_FETCH : S_EMIT;
         end
         S_FETCH: begin
            fetch_en = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               emit_en  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (access_en) begin
         res_ff.status   <= verdict.status;
         res_ff.i_sample <= '0;
         res_ff.q_sample <= '0;
      end
      if (fetch_en) begin
         res_ff.i_sample <= rd_data[IQ_W-1:0];
         res_ff.q_sample <= rd_data[WORD_W-1:IQ_W];
      end
      if (emit_en) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result beat only appears out of the hand-off state
   a_emit_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside hand-off");

   // RAM read data is only consumed right after a read was issued
   a_fetch_after_read: assert property (@(posedge clock) disable iff (reset)
      fetch_en |-> $past(mem_cmd.re))
      else $error("fetch without preceding RAM read");

   // Sample data is zero unless the status is ok
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_OK) |->
         (rsp_ff.i_sample == '0 && rsp_ff.q_sample == '0))
      else $error("sample data on failed status");

   // RAM is touched only in the access state
   a_mem_access_state: assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.we || mem_cmd.re) |-> state_ff == S_ACCESS)
      else $error("RAM access outside access state");

endmodule

`default_nettype wire
